// File: hw/rtl/hrlp_pkg.sv
// Package for the HTTP request line parser core.
// Holds result kind codes, character constants and register defaults.
// No dependencies.
package hrlp_pkg;

    // Result kinds
    localparam logic [2:0] K_URI   = 3'd0;
    localparam logic [2:0] K_VER   = 3'd1;
    localparam logic [2:0] K_OK    = 3'd2;
    localparam logic [2:0] K_UNSUP = 3'd3;
    localparam logic [2:0] K_BAD   = 3'd4;

    // Configuration register indexes
    localparam logic REG_URI_LIMIT = 1'b0;
    localparam logic REG_VER_LIMIT = 1'b1;

    // Characters
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_G  = 8'h47;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_S  = 8'h53;

    // Widths and defaults
    localparam int          URI_W             = 16;
    localparam int          VER_W             = 8;
    localparam logic [15:0] URI_LIMIT_RESET   = 16'd2048;
    localparam logic [7:0]  VER_LIMIT_RESET   = 8'd16;
    localparam int          METHOD_LIMIT_DEF  = 8;

endpackage

// File: hw/rtl/http_request_line_parser_core.sv
// HTTP request line parser: byte stream in, URI/version bytes and line status out.
// Depends on hrlp_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_data_byte) carries one byte of
//   the request line per beat. Output channel (o_out_valid / i_out_ready)
//   carries at most one result beat per input beat: a URI byte, a version
//   byte, line ok with method and field lengths, unsupported method, or bad
//   request. Skipped bytes, method bytes under the limit, spaces after a
//   known method or the URI, and the version's CR give no result. Results
//   are registered. One byte per cycle when not stalled; parsing is one pass
//   of compare and increment logic into the result register.
//   Stall: while a result waits on the output, the block still accepts a new
//   byte in the cycle the receiver takes the result; o_in_ready drops only
//   when the result register is full and i_out_ready is low.
//   Configuration: i_cfg_we writes uri_limit (index 0) or version_limit
//   (index 1) at once; write only while the block is idle.
//   Reset (synchronous, i_rst_n low): limits return to 2048 and 16, the
//   parser starts a new line in the method phase, the output is emptied.
module http_request_line_parser_core #(
    parameter int METHOD_LIMIT = hrlp_pkg::METHOD_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_method_code,
    output logic [15:0] o_uri_length,
    output logic [7:0]  o_version_length
);

    // Parser phases
    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_URI     = 3'd1;
    localparam logic [2:0] PH_VERSION = 3'd2;
    localparam logic [2:0] PH_WAIT_LF = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;

    localparam logic [16:0] METHOD_LIM = 17'(METHOD_LIMIT);

    // Configuration registers
    logic [15:0] r_uri_limit;
    logic [7:0]  r_ver_limit;

    // Parse state
    logic [2:0]  r_phase,     n_phase;
    logic [15:0] r_count,     n_count;
    logic [15:0] r_uri_count, n_uri_count;
    logic        r_get_match, n_get_match;   // method prefix still matches GET
    logic        r_post_match, n_post_match; // method prefix still matches POST
    logic        r_is_post,   n_is_post;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_kind,      n_kind;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic        r_method,    n_method;
    logic [15:0] r_uri_len,   n_uri_len;
    logic [7:0]  r_ver_len,   n_ver_len;

    logic        accept;
    logic        emit;
    logic [16:0] count_inc;
    logic        first;
    logic        known;

    // Take a new byte whenever the result register is empty or drains now.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign count_inc  = {1'b0, r_count} + 17'd1;
    assign first      = (r_count == 16'd0);
    assign known      = (r_count == 16'd3 && r_get_match) ||
                        (r_count == 16'd4 && r_post_match);

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_uri_count  = r_uri_count;
        n_get_match  = r_get_match;
        n_post_match = r_post_match;
        n_is_post    = r_is_post;
        emit         = 1'b0;
        n_kind       = hrlp_pkg::K_URI;
        n_out_byte   = 8'd0;
        n_method     = 1'b0;
        n_uri_len    = 16'd0;
        n_ver_len    = 8'd0;

        unique case (r_phase)
            PH_METHOD: begin
                if (i_data_byte == hrlp_pkg::CH_SP) begin
                    if (known) begin
                        n_phase   = PH_URI;
                        n_count   = 16'd0;
                        n_is_post = (r_count == 16'd4);
                    end else begin
                        emit   = 1'b1;
                        n_kind = hrlp_pkg::K_UNSUP;
                        n_phase = PH_SKIP;
                        n_count = 16'd0;
                    end
                end else begin
                    // Track the method prefix against GET and POST.
                    case (r_count)
                        16'd0: begin
                            n_get_match  = (i_data_byte == hrlp_pkg::CH_G);
                            n_post_match = (i_data_byte == hrlp_pkg::CH_P);
                        end
                        16'd1: begin
                            n_get_match  = r_get_match && (i_data_byte == hrlp_pkg::CH_E);
                            n_post_match = r_post_match && (i_data_byte == hrlp_pkg::CH_O);
                        end
                        16'd2: begin
                            n_get_match  = r_get_match && (i_data_byte == hrlp_pkg::CH_T);
                            n_post_match = r_post_match && (i_data_byte == hrlp_pkg::CH_S);
                        end
                        16'd3: begin
                            n_post_match = r_post_match && (i_data_byte == hrlp_pkg::CH_T);
                        end
                        default: begin
                            n_get_match  = r_get_match && !first;
                            n_post_match = r_post_match && !first;
                        end
                    endcase
                    n_count = count_inc[15:0];
                    if (count_inc >= METHOD_LIM) begin
                        emit    = 1'b1;
                        n_kind  = hrlp_pkg::K_BAD;
                        n_phase = (i_data_byte == hrlp_pkg::CH_LF) ? PH_METHOD : PH_SKIP;
                        n_count = 16'd0;
                    end
                end
            end
            PH_URI: begin
                if (i_data_byte == hrlp_pkg::CH_SP) begin
                    n_uri_count = r_count;
                    n_count     = 16'd0;
                    n_phase     = PH_VERSION;
                end else if (count_inc >= {1'b0, r_uri_limit}) begin
                    emit    = 1'b1;
                    n_kind  = hrlp_pkg::K_BAD;
                    n_phase = (i_data_byte == hrlp_pkg::CH_LF) ? PH_METHOD : PH_SKIP;
                    n_count = 16'd0;
                end else begin
                    emit       = 1'b1;
                    n_kind     = hrlp_pkg::K_URI;
                    n_out_byte = i_data_byte;
                    n_count    = count_inc[15:0];
                end
            end
            PH_VERSION: begin
                if (i_data_byte == hrlp_pkg::CH_CR) begin
                    n_phase = PH_WAIT_LF;
                end else if (count_inc >= {9'd0, r_ver_limit}) begin
                    emit    = 1'b1;
                    n_kind  = hrlp_pkg::K_BAD;
                    n_phase = (i_data_byte == hrlp_pkg::CH_LF) ? PH_METHOD : PH_SKIP;
                    n_count = 16'd0;
                end else begin
                    emit       = 1'b1;
                    n_kind     = hrlp_pkg::K_VER;
                    n_out_byte = i_data_byte;
                    n_count    = count_inc[15:0];
                end
            end
            PH_WAIT_LF: begin
                emit    = 1'b1;
                n_count = 16'd0;
                if (i_data_byte == hrlp_pkg::CH_LF) begin
                    n_kind    = hrlp_pkg::K_OK;
                    n_method  = r_is_post;
                    n_uri_len = r_uri_count;
                    n_ver_len = r_count[7:0];
                    n_phase   = PH_METHOD;
                end else begin
                    n_kind  = hrlp_pkg::K_BAD;
                    n_phase = PH_SKIP;
                end
            end
            default: begin
                // Skip up to the line feed that closes the failed line.
                if (i_data_byte == hrlp_pkg::CH_LF) begin
                    n_phase = PH_METHOD;
                    n_count = 16'd0;
                end
            end
        endcase
    end

    // Load a result on an accepted beat that produces one; drop it when taken.
    assign n_out_valid = (accept && emit) || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uri_limit  <= hrlp_pkg::URI_LIMIT_RESET;
            r_ver_limit  <= hrlp_pkg::VER_LIMIT_RESET;
            r_phase      <= PH_METHOD;
            r_count      <= 16'd0;
            r_uri_count  <= 16'd0;
            r_get_match  <= 1'b0;
            r_post_match <= 1'b0;
            r_is_post    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == hrlp_pkg::REG_URI_LIMIT) begin
                    r_uri_limit <= i_cfg_data;
                end else begin
                    r_ver_limit <= i_cfg_data[7:0];
                end
            end
            if (accept) begin
                r_phase      <= n_phase;
                r_count      <= n_count;
                r_uri_count  <= n_uri_count;
                r_get_match  <= n_get_match;
                r_post_match <= n_post_match;
                r_is_post    <= n_is_post;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload: no reset, loaded only with a new result.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_kind     <= n_kind;
            r_out_byte <= n_out_byte;
            r_method   <= n_method;
            r_uri_len  <= n_uri_len;
            r_ver_len  <= n_ver_len;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_out_byte       = r_out_byte;
    assign o_method_code    = r_method;
    assign o_uri_length     = r_uri_len;
    assign o_version_length = r_ver_len;

endmodule

// File: hw/rtl/hrlp_checker.sv
// Port-level checker for the HTTP request line parser core, with its bind.
// Depends on hrlp_pkg.
module hrlp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_out_byte,
    input logic        o_method_code,
    input logic [15:0] o_uri_length,
    input logic [7:0]  o_version_length
);

    // A stalled result beat holds its kind.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind))
        else $error("result beat changed while stalled");

    // An empty result register never blocks the input.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // Status beats carry no byte.
    a_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == hrlp_pkg::K_OK || o_kind == hrlp_pkg::K_UNSUP ||
                        o_kind == hrlp_pkg::K_BAD) |-> o_out_byte == 8'd0)
        else $error("status beat with nonzero byte");

    // Only line ok carries method and lengths.
    a_nolen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != hrlp_pkg::K_OK |->
            !o_method_code && o_uri_length == 16'd0 && o_version_length == 8'd0)
        else $error("lengths set on a non-ok beat");

endmodule

bind http_request_line_parser_core hrlp_checker u_hrlp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_kind           (o_kind),
    .o_out_byte       (o_out_byte),
    .o_method_code    (o_method_code),
    .o_uri_length     (o_uri_length),
    .o_version_length (o_version_length)
);
